>>> sv/mac_pkg.sv
// Shared types and constants for the moving-average crossover block.
// No dependencies; imported by every module of the block but mac_fifo.
package mac_pkg;

  localparam int SYM_BITS  = 4;
  localparam int PRICE_W   = 32;
  localparam int TIME_W    = 63;
  localparam int SUM_W     = 40;
  localparam int WIN_REG_W = 9;
  localparam int SIG_W     = 2;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 1'b1;

  localparam logic [WIN_REG_W-1:0] SHORT_WINDOW_RST = 9'd10;
  localparam logic [WIN_REG_W-1:0] LONG_WINDOW_RST  = 9'd50;

  // signal codes
  localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
  localparam logic [SIG_W-1:0] SIG_LONG = 2'd1;
  localparam logic [SIG_W-1:0] SIG_EXIT = 2'd2;

  typedef struct packed {
    logic                sym_ok;
    logic [SYM_BITS-1:0] symbol;
    logic [PRICE_W-1:0]  price;
    logic [TIME_W-1:0]   bar_time;
  } mac_item_t;

  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    logic [SIG_W-1:0]    signal;
    logic                history_ready;
    logic [TIME_W-1:0]   signal_time;
  } mac_result_t;

endpackage

>>> sv/mac_fifo.sv
// Small flop-based FIFO with an occupancy count.
// Used for the bar queue in the front end and the result queue in the back end.
module mac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    else return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        level <= level + LVL_W'(1);
      end else if (pop && !push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

  assign pop_data = mem[rd_ptr];

endmodule

>>> sv/mac_front.sv
// Front end: takes price bars, flags out-of-range symbols, queues them.
// Depends on mac_pkg and mac_fifo.
module mac_front #(
  parameter int SYMBOL_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mac_pkg::SYM_BITS-1:0]  symbol,
  input  logic [mac_pkg::PRICE_W-1:0]   price,
  input  logic [mac_pkg::TIME_W-1:0]    bar_time,
  output logic                          item_valid,
  output mac_pkg::mac_item_t            item,
  input  logic                          item_pop
);

  import mac_pkg::*;

  localparam int IN_DEPTH = 2;
  localparam int IN_LW    = $clog2(IN_DEPTH + 1);

  mac_item_t            beat;
  logic [IN_LW-1:0]     level;
  logic [$bits(mac_item_t)-1:0] head_bits;

  always_comb begin
    beat.sym_ok   = (32'(symbol) < SYMBOL_COUNT);
    beat.symbol   = symbol;
    beat.price    = price;
    beat.bar_time = bar_time;
  end

  assign in_ready   = (level < IN_LW'(IN_DEPTH));
  assign item_valid = (level != '0);
  assign item       = mac_item_t'(head_bits);

  mac_fifo #(
    .WIDTH ($bits(mac_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_bar_q (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_data (beat),
    .pop       (item_pop),
    .pop_data  (head_bits),
    .level     (level)
  );

endmodule

>>> sv/mac_back.sv
// Back end: per-symbol history memory, running sums, crossover compare, result queue.
// Depends on mac_pkg and mac_fifo.
module mac_back #(
  parameter int SYMBOL_COUNT = 16,
  parameter int MAX_WINDOW   = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  mac_pkg::mac_item_t             item,
  output logic                           item_pop,
  input  logic                           cfg_we,
  input  logic [mac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mac_pkg::WIN_REG_W-1:0]  cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mac_pkg::mac_result_t           result
);

  import mac_pkg::*;

  localparam int SYM_DEPTH = (SYMBOL_COUNT < (1 << SYM_BITS)) ? SYMBOL_COUNT : (1 << SYM_BITS);
  localparam int SYM_W     = (SYM_DEPTH > 1) ? $clog2(SYM_DEPTH) : 1;
  localparam int PW        = $clog2(MAX_WINDOW);
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int EXT_W     = CNT_W + 1;
  localparam int PROD_W    = SUM_W + CNT_W;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);

  // window registers
  logic [WIN_REG_W-1:0] win_short;
  logic [WIN_REG_W-1:0] win_long;
  logic [CNT_W-1:0]     sw;
  logic [CNT_W-1:0]     lw;

  // per-symbol state
  logic [CNT_W-1:0] seen      [SYM_DEPTH];
  logic [PW-1:0]    wpos      [SYM_DEPTH];
  logic [SUM_W-1:0] short_sum [SYM_DEPTH];
  logic [SUM_W-1:0] long_sum  [SYM_DEPTH];
  logic             held      [SYM_DEPTH];

  // price history, never cleared: entries are used only after a write
  logic [PRICE_W-1:0] hist [SYM_DEPTH][MAX_WINDOW];
  logic [PRICE_W-1:0] rd_short;
  logic [PRICE_W-1:0] rd_long;

  // issue stage
  logic             issue;
  logic [SYM_W-1:0] head_idx;
  logic [CNT_W-1:0] cur_seen;
  logic [CNT_W-1:0] seen_inc;
  logic [PW-1:0]    cur_wp;
  logic [PW-1:0]    wp_inc;
  logic [PW-1:0]    slot_s;
  logic [PW-1:0]    slot_l;

  // stage 1: sums
  logic                s1_valid;
  logic                s1_ok;
  logic                s1_rdy;
  logic                s1_sub_s;
  logic                s1_sub_l;
  logic [SYM_W-1:0]    s1_idx;
  logic [SYM_BITS-1:0] s1_symbol;
  logic [PRICE_W-1:0]  s1_price;
  logic [TIME_W-1:0]   s1_time;
  logic [SUM_W-1:0]    ss_next;
  logic [SUM_W-1:0]    ls_next;

  // stage 2: compare
  logic                s2_valid;
  logic                s2_ok;
  logic                s2_rdy;
  logic [SYM_W-1:0]    s2_idx;
  logic [SYM_BITS-1:0] s2_symbol;
  logic [TIME_W-1:0]   s2_time;
  logic [PROD_W-1:0]   s2_lhs;
  logic [PROD_W-1:0]   s2_rhs;
  logic [SIG_W-1:0]    sig;
  mac_result_t         res_in;

  logic [OUT_LW-1:0]             out_level;
  logic [$bits(mac_result_t)-1:0] out_bits;

  function automatic logic [CNT_W-1:0] eff_win(input logic [WIN_REG_W-1:0] w);
    if (w == '0) return CNT_W'(1);
    else if (32'(w) > MAX_WINDOW) return CNT_W'(MAX_WINDOW);
    else return CNT_W'(w);
  endfunction

  // slot of the price that drops out of a window of length w
  function automatic logic [PW-1:0] leave_slot(input logic [PW-1:0] wp,
                                               input logic [CNT_W-1:0] w);
    logic [EXT_W-1:0] diff;
    if (EXT_W'(wp) >= EXT_W'(w)) diff = EXT_W'(wp) - EXT_W'(w);
    else diff = EXT_W'(wp) + EXT_W'(MAX_WINDOW) - EXT_W'(w);
    return PW'(diff);
  endfunction

  assign sw = eff_win(win_short);
  assign lw = eff_win(win_long);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      win_short <= SHORT_WINDOW_RST;
      win_long  <= LONG_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_WINDOW: win_short <= cfg_data;
        REG_LONG_WINDOW:  win_long  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- issue ----------------
  // Issue is held while stage 1 is occupied: the sums of a symbol are read the cycle after
  // issue, so the previous beat's write-back is already in place.
  assign issue    = item_valid && !s1_valid &&
                    ((out_level + OUT_LW'(s2_valid)) < OUT_LW'(OUT_DEPTH));
  assign item_pop = issue;
  assign head_idx = item.symbol[SYM_W-1:0];

  always_comb begin
    cur_seen = seen[head_idx];
    cur_wp   = wpos[head_idx];
    seen_inc = (cur_seen < CNT_W'(MAX_WINDOW)) ? cur_seen + CNT_W'(1) : cur_seen;
    wp_inc   = (cur_wp == PW'(MAX_WINDOW - 1)) ? '0 : cur_wp + PW'(1);
    slot_s   = leave_slot(cur_wp, sw);
    slot_l   = leave_slot(cur_wp, lw);
  end

  always_ff @(posedge clk) begin
    if (issue && item.sym_ok) begin
      hist[head_idx][cur_wp] <= item.price;
    end
    if (issue) begin
      rd_short <= hist[head_idx][slot_s];
      rd_long  <= hist[head_idx][slot_l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int i = 0; i < SYM_DEPTH; i++) begin
        seen[i] <= '0;
        wpos[i] <= '0;
      end
    end else if (issue && item.sym_ok) begin
      seen[head_idx] <= seen_inc;
      wpos[head_idx] <= wp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ok     <= item.sym_ok;
      s1_rdy    <= (seen_inc >= sw) && (seen_inc >= lw);
      s1_sub_s  <= (cur_seen >= sw);
      s1_sub_l  <= (cur_seen >= lw);
      s1_idx    <= head_idx;
      s1_symbol <= item.symbol;
      s1_price  <= item.price;
      s1_time   <= item.bar_time;
    end
  end

  // ---------------- stage 1: running sums ----------------
  always_comb begin
    ss_next = short_sum[s1_idx] - (s1_sub_s ? SUM_W'(rd_short) : '0) + SUM_W'(s1_price);
    ls_next = long_sum[s1_idx]  - (s1_sub_l ? SUM_W'(rd_long)  : '0) + SUM_W'(s1_price);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int i = 0; i < SYM_DEPTH; i++) begin
        short_sum[i] <= '0;
        long_sum[i]  <= '0;
      end
    end else if (s1_valid && s1_ok) begin
      short_sum[s1_idx] <= ss_next;
      long_sum[s1_idx]  <= ls_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // cross-multiply: short_sum * long_w against long_sum * short_w
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_ok     <= s1_ok;
      s2_rdy    <= s1_rdy;
      s2_idx    <= s1_idx;
      s2_symbol <= s1_symbol;
      s2_time   <= s1_time;
      s2_lhs    <= PROD_W'(ss_next) * PROD_W'(lw);
      s2_rhs    <= PROD_W'(ls_next) * PROD_W'(sw);
    end
  end

  // ---------------- stage 2: crossover decision ----------------
  always_comb begin
    sig = SIG_NONE;
    if (s2_ok && s2_rdy) begin
      if ((s2_lhs > s2_rhs) && !held[s2_idx]) begin
        sig = SIG_LONG;
      end else if ((s2_lhs < s2_rhs) && held[s2_idx]) begin
        sig = SIG_EXIT;
      end
    end
    res_in.symbol        = s2_symbol;
    res_in.signal        = sig;
    res_in.history_ready = s2_ok && s2_rdy;
    res_in.signal_time   = s2_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SYM_DEPTH; i++) begin
        held[i] <= 1'b0;
      end
    end else if (s2_valid) begin
      if (sig == SIG_LONG) begin
        held[s2_idx] <= 1'b1;
      end else if (sig == SIG_EXIT) begin
        held[s2_idx] <= 1'b0;
      end
    end
  end

  // ---------------- result queue ----------------
  assign out_valid = (out_level != '0);
  assign result    = mac_result_t'(out_bits);

  mac_fifo #(
    .WIDTH ($bits(mac_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (res_in),
    .pop       (out_valid && out_ready),
    .pop_data  (out_bits),
    .level     (out_level)
  );

endmodule

>>> sv/moving_average_crossover.sv
// Top level of the moving-average crossover block.
// Depends on mac_pkg, mac_front and mac_back.
//
// Takes one price bar per input beat and returns one result beat per bar, in order.
// A bar does not issue while the previous one is in the back end's sum stage: each
// bar reads its symbol's running sums the cycle after issue and writes them back
// before the next issue. The bar queue (2 deep) and result queue (4 deep) let either
// side stall without blocking the other until a queue fills. The price history is a
// min(SYMBOL_COUNT, 16) x MAX_WINDOW x 32-bit memory with no clearing pass; a write
// to either window register restarts every symbol's history and sums but keeps the
// held flags. The user must write configuration only while no bar is in flight;
// the block itself does not enforce this.
module moving_average_crossover #(
  parameter int SYMBOL_COUNT = 16,
  parameter int MAX_WINDOW   = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mac_pkg::SYM_BITS-1:0]   symbol,
  input  logic [mac_pkg::PRICE_W-1:0]    price,
  input  logic [mac_pkg::TIME_W-1:0]     bar_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mac_pkg::SYM_BITS-1:0]   out_symbol,
  output logic [mac_pkg::SIG_W-1:0]      signal,
  output logic                           history_ready,
  output logic [mac_pkg::TIME_W-1:0]     signal_time,
  input  logic                           cfg_we,
  input  logic [mac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mac_pkg::WIN_REG_W-1:0]  cfg_data
);

  import mac_pkg::*;

  logic        item_valid;
  logic        item_pop;
  mac_item_t   item;
  mac_result_t result;

  mac_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .symbol     (symbol),
    .price      (price),
    .bar_time   (bar_time),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  mac_back #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign out_symbol    = result.symbol;
  assign signal        = result.signal;
  assign history_ready = result.history_ready;
  assign signal_time   = result.signal_time;

endmodule

>>> tb/moving_average_crossover_test.sv
`timescale 1ns / 1ps
// Self-checking bench for moving_average_crossover: a directed table of bars and
// window writes, then random window phases, checked against typed rows or a crossover model.
// Depends on mac_pkg and the moving_average_crossover RTL.
module moving_average_crossover_test;
  import mac_pkg::*;

  localparam int SYMBOLS = 16;
  localparam int HIST_DEPTH = 256;
  localparam int QUIET_LIMIT = 4000;
  localparam longint PRICE_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int DIRECTED_ROWS = 25;

  typedef enum logic {ROW_BAR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [WIN_REG_W-1:0] short_w;
    logic [WIN_REG_W-1:0] long_w;
    logic [SYM_BITS-1:0]  sym;
    logic [PRICE_W-1:0]   price;
    logic [TIME_W-1:0]    stamp;
    logic                 typed;
    logic [SIG_W-1:0]     sig;
    logic                 ready;
  } bar_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [SYM_BITS-1:0]  symbol;
  logic [PRICE_W-1:0]   price;
  logic [TIME_W-1:0]    bar_time;
  logic                 out_valid;
  logic                 out_ready;
  logic [SYM_BITS-1:0]  out_symbol;
  logic [SIG_W-1:0]     signal;
  logic                 history_ready;
  logic [TIME_W-1:0]    signal_time;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIN_REG_W-1:0] cfg_data;

  // crossover model state
  logic [PRICE_W-1:0]   hist_model [SYMBOLS][HIST_DEPTH];
  int unsigned          wpos_model [SYMBOLS];
  int unsigned          seen_model [SYMBOLS];
  logic [SUM_W-1:0]     short_sum_model [SYMBOLS];
  logic [SUM_W-1:0]     long_sum_model [SYMBOLS];
  bit                   held_model [SYMBOLS];
  logic [WIN_REG_W-1:0] short_reg;
  logic [WIN_REG_W-1:0] long_reg;

  mac_result_t          pending_signals [$];
  int                   mismatches = 0;
  int                   quiet_cycles = 0;
  int                   burst_left = 0;
  logic [PRICE_W-1:0]   level [SYMBOLS];

  // The first three rows run on the reset windows (10/50): never ready.
  bar_row_t directed_bars [DIRECTED_ROWS] = '{
    '{ROW_BAR, 9'd0, 9'd0, 4'd0, 32'd0, 63'd0, 1'b1, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd15, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd7, 32'hAAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1, SIG_NONE, 1'b0},
    '{ROW_CFG, 9'd1, 9'd2, 4'd0, 32'd0, 63'd0, 1'b0, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd100, 63'd1, 1'b1, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd200, 63'd2, 1'b1, SIG_LONG, 1'b1},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd50, 63'd3, 1'b1, SIG_EXIT, 1'b1},
    // equal averages: ready, no change
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd50, 63'd4, 1'b1, SIG_NONE, 1'b1},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd60, 63'd5, 1'b1, SIG_LONG, 1'b1},
    '{ROW_BAR, 9'd0, 9'd0, 4'd12, 32'hFFFF_FFFF, 63'd6, 1'b1, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd12, 32'hFFFF_FFFF, 63'd7, 1'b1, SIG_NONE, 1'b1},
    '{ROW_BAR, 9'd0, 9'd0, 4'd12, 32'd0, 63'd8, 1'b1, SIG_NONE, 1'b1},
    // zero window acts as one
    '{ROW_CFG, 9'd0, 9'd1, 4'd0, 32'd0, 63'd0, 1'b0, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd5, 63'd9, 1'b1, SIG_NONE, 1'b1},
    '{ROW_CFG, 9'd2, 9'd511, 4'd0, 32'd0, 63'd0, 1'b0, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd1000, 63'd10, 1'b1, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd0, 32'hFFFF_FFFF, 63'd11, 1'b1, SIG_NONE, 1'b0},
    '{ROW_CFG, 9'd256, 9'd0, 4'd0, 32'd0, 63'd0, 1'b0, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd9, 32'd123, 63'd12, 1'b1, SIG_NONE, 1'b0},
    '{ROW_CFG, 9'd1, 9'd3, 4'd0, 32'd0, 63'd0, 1'b0, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd10, 63'd13, 1'b1, SIG_NONE, 1'b0},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd10, 63'd14, 1'b1, SIG_NONE, 1'b0},
    // symbol 3 still holds from before the window writes
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd1, 63'd15, 1'b1, SIG_EXIT, 1'b1},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd30, 63'd16, 1'b1, SIG_LONG, 1'b1},
    '{ROW_BAR, 9'd0, 9'd0, 4'd3, 32'd7, 63'd17, 1'b0, SIG_NONE, 1'b0}
  };

  moving_average_crossover dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .symbol        (symbol),
    .price         (price),
    .bar_time      (bar_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_symbol    (out_symbol),
    .signal        (signal),
    .history_ready (history_ready),
    .signal_time   (signal_time),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void restart_history();
    for (int i = 0; i < SYMBOLS; i++) begin
      wpos_model[i] = 0;
      seen_model[i] = 0;
      short_sum_model[i] = '0;
      long_sum_model[i] = '0;
    end
  endfunction

  function automatic int unsigned eff_window(logic [WIN_REG_W-1:0] w);
    if (w == 0) return 1;
    if (w > HIST_DEPTH) return HIST_DEPTH;
    return 32'(w);
  endfunction

  function automatic mac_result_t predict_crossover(logic [SYM_BITS-1:0] s,
                                                    logic [PRICE_W-1:0] p,
                                                    logic [TIME_W-1:0] t);
    mac_result_t r;
    int unsigned sw, lw, wp, seen;
    logic [SUM_W-1:0] ss, ls;
    logic [63:0] lhs, rhs;
    sw = eff_window(short_reg);
    lw = eff_window(long_reg);
    wp = wpos_model[s];
    seen = seen_model[s];
    ss = short_sum_model[s];
    ls = long_sum_model[s];
    // drop the bar leaving each window before adding the new one
    if (seen >= sw) ss = ss - SUM_W'(hist_model[s][(wp + HIST_DEPTH - sw) % HIST_DEPTH]);
    if (seen >= lw) ls = ls - SUM_W'(hist_model[s][(wp + HIST_DEPTH - lw) % HIST_DEPTH]);
    ss = ss + SUM_W'(p);
    ls = ls + SUM_W'(p);
    hist_model[s][wp] = p;
    wpos_model[s] = (wp + 1) % HIST_DEPTH;
    if (seen < HIST_DEPTH) seen++;
    seen_model[s] = seen;
    short_sum_model[s] = ss;
    long_sum_model[s] = ls;
    r.symbol = s;
    r.signal = SIG_NONE;
    r.history_ready = 1'b0;
    r.signal_time = t;
    if (seen >= sw && seen >= lw) begin
      lhs = 64'(ss) * 64'(lw);
      rhs = 64'(ls) * 64'(sw);
      r.history_ready = 1'b1;
      if (lhs > rhs && !held_model[s]) begin
        r.signal = SIG_LONG;
        held_model[s] = 1'b1;
      end else if (lhs < rhs && held_model[s]) begin
        r.signal = SIG_EXIT;
        held_model[s] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [WIN_REG_W-1:0] pick_window();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return 9'd1;
    if (roll == 2) return 9'($urandom_range(256, 511));
    return 9'($urandom_range(2, 12));
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  // Called at a clock edge; returns at the edge where the beat was taken (or after a gap).
  task automatic send_bar(logic [SYM_BITS-1:0] s, logic [PRICE_W-1:0] p,
                          logic [TIME_W-1:0] t, bit typed, logic [SIG_W-1:0] want_sig,
                          logic want_ready);
    mac_result_t r;
    in_valid <= 1'b1;
    symbol <= s;
    price <= p;
    bar_time <= t;
    do @(posedge clk); while (!in_ready);
    r = predict_crossover(s, p, t);
    if (typed) begin
      r.signal = want_sig;
      r.history_ready = want_ready;
    end
    pending_signals.push_back(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_signals.size() != 0) @(posedge clk);
  endtask

  // either write restarts every symbol's history
  task automatic configure(bit do_s, logic [WIN_REG_W-1:0] sw, bit do_l,
                           logic [WIN_REG_W-1:0] lw);
    if (do_s) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_SHORT_WINDOW;
      cfg_data <= sw;
      short_reg = sw;
      restart_history();
      @(posedge clk);
    end
    if (do_l) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_LONG_WINDOW;
      cfg_data <= lw;
      long_reg = lw;
      restart_history();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int mode, span;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int c = 0; c < span; c++) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (c % 6) < 3;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    mac_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_signals.size() == 0) begin
        report_mismatch("result beat with nothing pending", 64'(signal_time), 64'(0));
      end else begin
        want = pending_signals.pop_front();
        if (out_symbol !== want.symbol)
          report_mismatch("out_symbol", 64'(out_symbol), 64'(want.symbol));
        if (signal !== want.signal)
          report_mismatch("signal", 64'(signal), 64'(want.signal));
        if (history_ready !== want.history_ready)
          report_mismatch("history_ready", 64'(history_ready), 64'(want.history_ready));
        if (signal_time !== want.signal_time)
          report_mismatch("signal_time", 64'(signal_time), 64'(want.signal_time));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL moving_average_crossover");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int n_items, n_active, roll;
    int unsigned step;
    longint walk;
    logic [SYM_BITS-1:0] s;
    logic [SYM_BITS-1:0] active [3];
    bit do_s, do_l;
    logic [WIN_REG_W-1:0] sw, lw;

    rst = 1'b1;
    in_valid = 1'b0;
    symbol = '0;
    price = '0;
    bar_time = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SHORT_WINDOW;
    cfg_data = '0;
    short_reg = SHORT_WINDOW_RST;
    long_reg = LONG_WINDOW_RST;
    restart_history();
    foreach (held_model[i]) held_model[i] = 1'b0;
    foreach (level[i]) level[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bars[i]) begin
      if (directed_bars[i].kind == ROW_CFG) begin
        wait_idle();
        configure(1'b1, directed_bars[i].short_w, 1'b1, directed_bars[i].long_w);
      end else begin
        send_bar(directed_bars[i].sym, directed_bars[i].price, directed_bars[i].stamp,
                 directed_bars[i].typed, directed_bars[i].sig, directed_bars[i].ready);
      end
    end

    // Phase 3 fills the largest windows on one symbol with prices near the top of range;
    // the rest use mostly short windows on a few busy symbols so crossovers come often.
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 3) begin
        sw = 9'($urandom_range(128, 255));
        lw = ($urandom_range(0, 1) == 0) ? 9'd256 : 9'($urandom_range(257, 511));
        do_s = 1'b1;
        do_l = 1'b1;
        n_items = 300;
        n_active = 1;
      end else begin
        sw = pick_window();
        lw = pick_window();
        do_s = ($urandom_range(0, 3) != 0);
        do_l = !do_s || ($urandom_range(0, 3) != 0);
        n_items = 20;
        n_active = $urandom_range(1, 3);
      end
      configure(do_s, sw, do_l, lw);
      for (int k = 0; k < 3; k++) begin
        active[k] = 4'($urandom_range(0, SYMBOLS - 1));
        level[active[k]] = (ph == 3) ? 32'hFFFF_0000 : $urandom;
      end
      for (int n = 0; n < n_items; n++) begin
        if (ph != 3 && $urandom_range(0, 9) == 0)
          s = 4'($urandom_range(0, SYMBOLS - 1));
        else
          s = active[$urandom_range(0, n_active - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          level[s] = roll[0] ? '1 : '0;
        end else if (roll < 10) begin
          level[s] = $urandom;
        end else begin
          // random walk keeps the averages close so they cross back and forth
          step = ($urandom_range(0, 3) == 0) ? (1 << 20) : 4096;
          walk = longint'(level[s]) + longint'($urandom_range(0, 2 * step)) - longint'(step);
          if (walk < 0) walk = 0;
          else if (walk > PRICE_MAX) walk = PRICE_MAX;
          level[s] = walk[31:0];
        end
        send_bar(s, level[s], 63'({$urandom, $urandom}), 1'b0, SIG_NONE, 1'b0);
      end
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_signals.size() == 0) begin
      $display("PASS moving_average_crossover");
    end else begin
      $display("FAIL moving_average_crossover");
    end
    $finish;
  end

endmodule
